// ===== hdl/tpjd_pkg.sv =====
// Shared types and constants of the timed priority job dispatcher.
// No dependencies; every file of the block but tpjd_ram imports this package.
package tpjd_pkg;

	localparam int SLOTS_DEF   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int CNT_W       = $clog2(MAX_RESULTS);

	localparam int JOB_W  = 8;
	localparam int TIME_W = 32;
	localparam int PRI_W  = 8;
	localparam int IVL_W  = 16;

	// Stream payload widths
	localparam int S_TDATA_W = 72;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 8;
	localparam int M_TUSER_W = 1;

	// Action codes carried on s_tuser
	localparam logic ACT_SUBMIT = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	// Result status codes carried on m_tuser
	localparam logic STAT_DISPATCHED = 1'b0;
	localparam logic STAT_FULL       = 1'b1;

	// One stored job
	typedef struct packed {
		logic [IVL_W-1:0]  interval;
		logic              repeat_en;
		logic [PRI_W-1:0]  pri;
		logic [TIME_W-1:0] due;
		logic [JOB_W-1:0]  job;
	} tpjd_rec_t;

	localparam int REC_W = $bits(tpjd_rec_t);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DUE_SCAN,
		S_SEL_SCAN,
		S_PUT,
		S_REJECT
	} tpjd_state_t;

	// Controller to datapath
	typedef struct packed {
		logic store;       // write the submitted job into the lowest free slot
		logic tick;        // advance time, clear result count
		logic hold_rej;    // latch the id of a job that does not fit
		logic scan_start;  // start a pass over all slots
		logic sel_mode;    // pass picks the best due job (else it marks due slots)
		logic put;         // emit best job, write it back or free it
		logic reject;      // emit the full-table result
	} tpjd_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic free_any;   // some slot is free
		logic scan_done;  // final slot of the pass is being processed
		logic found;      // the selection pass has a candidate
		logic last_res;   // the pending result closes the tick
		logic out_free;   // output register can take a result
	} tpjd_sts_t;

endpackage

// ===== hdl/tpjd_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module tpjd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hdl/tpjd_ctrl.sv =====
// Controller state machine of the job dispatcher: sequences submits, due
// scans, selection passes and result emission. Depends on tpjd_pkg.
module tpjd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_action,
	output logic               in_ready,
	input  tpjd_pkg::tpjd_sts_t sts,
	output tpjd_pkg::tpjd_cmd_t cmd
);
	import tpjd_pkg::*;

	tpjd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_action == ACT_TICK) begin
						cmd.tick       = 1'b1;
						cmd.scan_start = 1'b1;
						state_d        = S_DUE_SCAN;
					end else if (sts.free_any) begin
						cmd.store = 1'b1;
					end else begin
						cmd.hold_rej = 1'b1;
						state_d      = S_REJECT;
					end
				end
			end
			S_DUE_SCAN: begin
				if (sts.scan_done) begin
					cmd.scan_start = 1'b1;
					cmd.sel_mode   = 1'b1;
					state_d        = S_SEL_SCAN;
				end
			end
			S_SEL_SCAN: begin
				cmd.sel_mode = 1'b1;
				if (sts.scan_done) begin
					state_d = sts.found ? S_PUT : S_IDLE;
				end
			end
			S_PUT: begin
				cmd.sel_mode = 1'b1;
				if (sts.out_free) begin
					cmd.put = 1'b1;
					if (sts.last_res) begin
						state_d = S_IDLE;
					end else begin
						cmd.scan_start = 1'b1;
						state_d        = S_SEL_SCAN;
					end
				end
			end
			S_REJECT: begin
				if (sts.out_free) begin
					cmd.reject = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hdl/tpjd_dp.sv =====
// Datapath of the job dispatcher: slot table in RAM, valid and due flags,
// time counter, scan pipeline, best-job register and output register.
// Depends on tpjd_pkg and tpjd_ram.
module tpjd_dp #(
	parameter int SLOTS = tpjd_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tpjd_pkg::tpjd_rec_t        in_rec,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [tpjd_pkg::JOB_W-1:0] out_job_id,
	output logic                       out_status,
	output logic                       out_last,
	input  tpjd_pkg::tpjd_cmd_t        cmd,
	output tpjd_pkg::tpjd_sts_t        sts
);
	import tpjd_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	logic [TIME_W-1:0] time_q;
	logic [SLOTS-1:0]  valid_q;
	logic [SLOTS-1:0]  due_q;
	logic [IW-1:0]     rd_idx_q;
	logic              rd_act_q;
	logic              sel_mode_q;
	logic              vld_s1;
	logic [IW-1:0]     idx_s1;
	logic              found_q;
	tpjd_rec_t         best_q;
	logic [IW-1:0]     best_idx_q;
	logic [CNT_W-1:0]  n_q;
	logic [JOB_W-1:0]  rej_job_q;
	logic              out_vld_q;
	logic [JOB_W-1:0]  out_job_q;
	logic              out_stat_q;
	logic              out_last_q;

	logic [IW-1:0]     free_idx;
	logic              free_any;
	logic [REC_W-1:0]  rd_data;
	tpjd_rec_t         rd_rec;
	logic              hit;
	logic [SLOTS-1:0]  rest_due;
	logic [IVL_W-1:0]  step;
	tpjd_rec_t         wb_rec;
	logic              we;
	logic [IW-1:0]     waddr;
	logic [REC_W-1:0]  wdata;

	// Lowest free slot
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IW'(i);
				free_any = 1'b1;
			end
		end
	end

	assign rd_rec = tpjd_rec_t'(rd_data);
	assign hit    = vld_s1 && sel_mode_q && due_q[idx_s1]
		&& (!found_q || rd_rec.pri > best_q.pri);

	always_comb begin
		rest_due             = due_q;
		rest_due[best_idx_q] = 1'b0;
	end

	// Recurring job: next due is now plus interval, zero counts as one
	assign step   = (best_q.interval == '0) ? IVL_W'(1) : best_q.interval;
	always_comb begin
		wb_rec     = best_q;
		wb_rec.due = time_q + {{(TIME_W - IVL_W){1'b0}}, step};
	end

	assign we    = cmd.store || (cmd.put && best_q.repeat_en);
	assign waddr = cmd.store ? free_idx : best_idx_q;
	assign wdata = cmd.store ? REC_W'(in_rec) : REC_W'(wb_rec);

	tpjd_ram #(
		.WIDTH(REC_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_act_q),
		.raddr (rd_idx_q),
		.rdata (rd_data)
	);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q     <= '0;
			valid_q    <= '0;
			due_q      <= '0;
			rd_idx_q   <= '0;
			rd_act_q   <= 1'b0;
			sel_mode_q <= 1'b0;
			vld_s1     <= 1'b0;
			found_q    <= 1'b0;
			n_q        <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cmd.tick) begin
				time_q <= time_q + TIME_W'(1);
				n_q    <= '0;
			end
			if (cmd.store) begin
				valid_q[free_idx] <= 1'b1;
			end
			// Scan pipeline: address stage, then data stage
			vld_s1 <= rd_act_q;
			if (cmd.scan_start) begin
				rd_idx_q   <= '0;
				rd_act_q   <= 1'b1;
				sel_mode_q <= cmd.sel_mode;
				found_q    <= 1'b0;
			end else if (rd_act_q) begin
				if (rd_idx_q == LAST_IDX) begin
					rd_act_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + IW'(1);
				end
			end
			if (vld_s1 && !sel_mode_q) begin
				due_q[idx_s1] <= valid_q[idx_s1] && (rd_rec.due <= time_q);
			end
			if (hit) begin
				found_q <= 1'b1;
			end
			if (cmd.put) begin
				due_q[best_idx_q] <= 1'b0;
				n_q               <= n_q + CNT_W'(1);
				if (!best_q.repeat_en) begin
					valid_q[best_idx_q] <= 1'b0;
				end
			end
			if (cmd.put || cmd.reject) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (rd_act_q) begin
			idx_s1 <= rd_idx_q;
		end
		if (hit) begin
			best_q     <= rd_rec;
			best_idx_q <= idx_s1;
		end
		if (cmd.hold_rej) begin
			rej_job_q <= in_rec.job;
		end
		if (cmd.put) begin
			out_job_q  <= best_q.job;
			out_stat_q <= STAT_DISPATCHED;
			out_last_q <= sts.last_res;
		end else if (cmd.reject) begin
			out_job_q  <= rej_job_q;
			out_stat_q <= STAT_FULL;
			out_last_q <= 1'b1;
		end
	end

	assign sts.free_any  = free_any;
	assign sts.scan_done = vld_s1 && (idx_s1 == LAST_IDX);
	assign sts.found     = found_q || hit;
	assign sts.last_res  = (rest_due == '0) || (n_q == CNT_W'(MAX_RESULTS - 1));
	assign sts.out_free  = !out_vld_q || out_ready;

	assign out_valid  = out_vld_q;
	assign out_job_id = out_job_q;
	assign out_status = out_stat_q;
	assign out_last   = out_last_q;

endmodule

// ===== hdl/timed_priority_job_dispatcher.sv =====
// Top level of the timed priority job dispatcher: stream ports, controller
// and datapath. Depends on tpjd_pkg, tpjd_ctrl, tpjd_dp and tpjd_ram.
//
//  port group | dir | tdata (low bit up)                              | tuser  | tlast
//  s_         | in  | job_id, due_time, job_priority, recurring,      | action | -
//             |     | repeat_interval, 7 zero bits                    |        |
//  m_         | out | out_job_id                                      | status | last
//
// Submit: a job is stored when a slot is free; a job that finds the table full
// goes through the reject state and any wait for the output register.
// Tick: a due scan, then per dispatched job one selection pass through the
// slot RAM read port plus one emit step; a tick with nothing due spends one
// empty selection pass instead.
// Output stalls hold the emit step and the input; reset clears time and flags.
module timed_priority_job_dispatcher #(
	parameter int SLOTS = tpjd_pkg::SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tpjd_pkg::S_TDATA_W-1:0] s_tdata,  // job_id, due_time, job_priority, recurring, repeat_interval
	input  logic [tpjd_pkg::S_TUSER_W-1:0] s_tuser,  // action
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tpjd_pkg::M_TDATA_W-1:0] m_tdata,  // out_job_id
	output logic [tpjd_pkg::M_TUSER_W-1:0] m_tuser,  // status
	output logic                           m_tlast
);
	import tpjd_pkg::*;

	tpjd_cmd_t cmd;
	tpjd_sts_t sts;
	tpjd_rec_t in_rec;

	assign in_rec.job       = s_tdata[7:0];
	assign in_rec.due       = s_tdata[39:8];
	assign in_rec.pri       = s_tdata[47:40];
	assign in_rec.repeat_en = s_tdata[48];
	assign in_rec.interval  = s_tdata[64:49];

	tpjd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_action (s_tuser[0]),
		.in_ready  (s_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tpjd_dp #(
		.SLOTS(SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_rec     (in_rec),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_job_id (m_tdata),
		.out_status (m_tuser[0]),
		.out_last   (m_tlast),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

// ===== hdl/tpjd_checker.sv =====
// Port-level checks of the timed priority job dispatcher, bound to the top.
// Depends on tpjd_pkg and timed_priority_job_dispatcher.
module tpjd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [tpjd_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [tpjd_pkg::S_TUSER_W-1:0] s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [tpjd_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [tpjd_pkg::M_TUSER_W-1:0] m_tuser,
	input logic                           m_tlast
);
	import tpjd_pkg::*;

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
			&& $stable(m_tuser) && $stable(m_tlast))
		else $error("stalled result changed");

	// Full-table result always closes its item
	a_rej_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == STAT_FULL) |-> m_tlast)
		else $error("reject result without last");

	// A tick run is still open while a non-final result is shown
	a_busy_mid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input taken in the middle of a tick");

	// Input is not ready in the cycle after a tick is accepted
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[0] == ACT_TICK) |=> !s_tready)
		else $error("ready right after a tick");

endmodule

bind timed_priority_job_dispatcher tpjd_checker u_tpjd_checker (.*);
